// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clock edge, switched off while reset is asserted.
`define ASSERT_CLKRST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define ASSERT_CLK(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lcg48_pkg.sv
package lcg48_pkg;

  localparam int unsigned StateW = 48;
  localparam int unsigned HalfW  = 24;
  localparam int unsigned JoinW  = 54;
  localparam int unsigned ValW   = 55;
  localparam int unsigned ByteW  = 9;

  // Multiplier 0x5DEECE66D split at bit 24.
  localparam logic [HalfW-1:0] LcgMulLo = 24'hECE66D;
  localparam logic [HalfW-1:0] LcgMulHi = 24'h0005DE;
  localparam logic [StateW-1:0] LcgAdd  = 48'hB;
  localparam logic [31:0] SeedXor       = 32'hDEECE66D;

  typedef logic [4:0] perm_t [32];
  localparam perm_t SeedPerm = '{
    5'd17, 5'd19, 5'd21, 5'd23, 5'd25, 5'd27, 5'd29, 5'd31,
    5'd1,  5'd3,  5'd5,  5'd7,  5'd9,  5'd11, 5'd13, 5'd15,
    5'd16, 5'd18, 5'd20, 5'd22, 5'd24, 5'd26, 5'd28, 5'd30,
    5'd0,  5'd2,  5'd4,  5'd6,  5'd8,  5'd10, 5'd12, 5'd14
  };

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  typedef enum logic {
    REQ_SEED = 1'b0,
    REQ_DRAW = 1'b1
  } req_e;

  // Seed scramble: low 16 bits fold the time's top and bottom, the upper 32 bits
  // are the XORed low word with its bits moved by the permutation table.
  function automatic logic [StateW-1:0] scramble_seed(input logic [StateW-1:0] t);
    logic [31:0] w;
    logic [31:0] hi;
    logic [15:0] lo;
    w  = t[31:0] ^ SeedXor;
    hi = '0;
    for (int i = 0; i < 32; i++) begin
      hi[SeedPerm[i]] = w[i];
    end
    lo = t[47:32] ^ t[15:0];
    return {hi, lo};
  endfunction

  // Round to even when bit 53 is set; all ones carries to exactly 2^54.
  function automatic logic [ValW-1:0] round_value(input logic [JoinW-1:0] v);
    logic [ValW-1:0] r;
    r = {1'b0, v};
    if (v[JoinW-1] && v[0]) begin
      r[0] = 1'b0;
      if (r[1]) begin
        r = r + ValW'(2);
      end
    end
    return r;
  endfunction

endpackage

// File: rtl/lcg48_seeded_random_draw.sv
// Seeded 48-bit linear congruential random source.
// Input channel (s_axis): tuser selects the request, 0 reseeds the generator
// from the 48-bit millisecond time in tdata, 1 draws the next value (tdata is
// then ignored). Output channel (m_axis): one word per draw, carrying the
// rounded 55-bit value and its top byte; a reseed gives no word.
// A reseed loads the generator state and leaves the block idle and ready.
// A draw advances the state twice; each advance is three partial products of
// one shared 24x24 multiply-accumulate unit. The joined result is then rounded
// and written with its top byte to the output register; the block takes no
// new request from acceptance of a draw until its word is written.
// A finished word waits in the output register. If the receiver stalls, the
// block still takes the next request; a following draw then waits in its last
// step until the pending word is taken.
// Reset clears the generator state to zero and empties the output register.
module lcg48_seeded_random_draw (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // epoch_ms[47:0]
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata    // rounded_value[54:0], top_byte[63:55]
);

  lcg48_pkg::state_e st_q, st_d;
  logic [1:0]  step_q, step_d;
  logic        half_q, half_d;
  logic [47:0] lcg_q, lcg_d;
  logic [47:0] acc_q, acc_d;
  logic [26:0] s1_q, s1_d;
  logic [53:0] join_q, join_d;
  logic        ovalid_q, ovalid_d;
  logic [63:0] odata_q, odata_d;

  logic [23:0] mul_a, mul_b;
  logic [47:0] prod;
  logic [47:0] sum;
  logic [54:0] rounded;
  logic        in_acc;
  logic        out_free;

  assign s_axis_tready = (st_q == lcg48_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !ovalid_q || m_axis_tready;

  // Partial products: lo*lo, then lo*hi and hi*lo shifted by 24; hi*hi drops out.
  always_comb begin
    mul_a = (step_q == 2'd2) ? lcg_q[47:24] : lcg_q[23:0];
    mul_b = (step_q == 2'd1) ? lcg48_pkg::LcgMulHi : lcg48_pkg::LcgMulLo;
  end

  assign prod = mul_a * mul_b;

  always_comb begin
    if (step_q == 2'd0) begin
      sum = prod + lcg48_pkg::LcgAdd;
    end else begin
      sum = acc_q + {prod[23:0], 24'b0};
    end
  end

  assign rounded = lcg48_pkg::round_value(join_q);

  always_comb begin
    st_d     = st_q;
    step_d   = step_q;
    half_d   = half_q;
    lcg_d    = lcg_q;
    acc_d    = acc_q;
    s1_d     = s1_q;
    join_d   = join_q;
    ovalid_d = ovalid_q && !m_axis_tready;
    odata_d  = odata_q;
    case (st_q)
      lcg48_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (s_axis_tuser == lcg48_pkg::REQ_DRAW) begin
            st_d   = lcg48_pkg::ST_MUL;
            step_d = 2'd0;
            half_d = 1'b0;
          end else begin
            lcg_d = lcg48_pkg::scramble_seed(s_axis_tdata);
          end
        end
      end
      lcg48_pkg::ST_MUL: begin
        acc_d = sum;
        if (step_q == 2'd2) begin
          lcg_d  = sum;
          step_d = 2'd0;
          if (!half_q) begin
            s1_d   = sum[47:21];
            half_d = 1'b1;
          end else begin
            join_d = {s1_q, sum[47:21]};
            st_d   = lcg48_pkg::ST_DONE;
          end
        end else begin
          step_d = step_q + 2'd1;
        end
      end
      lcg48_pkg::ST_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          odata_d  = {rounded[54:46], rounded};
          st_d     = lcg48_pkg::ST_IDLE;
        end
      end
      default: begin
        st_d = lcg48_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= lcg48_pkg::ST_IDLE;
      step_q   <= 2'd0;
      half_q   <= 1'b0;
      lcg_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      step_q   <= step_d;
      half_q   <= half_d;
      lcg_q    <= lcg_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    s1_q    <= s1_d;
    join_q  <= join_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;

endmodule

// File: rtl/lcg48_checker.sv
`include "assert_macros.svh"

module lcg48_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  logic draw_acc;
  assign draw_acc = s_axis_tvalid && s_axis_tready && s_axis_tuser;

  // A stalled word keeps its valid.
  `ASSERT_CLKRST(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "output word dropped while stalled")

  // A draw keeps the block busy through both generator advances.
  `ASSERT_CLKRST(a_draw_busy, clk_i, rst_ni, draw_acc |=> !s_axis_tready ##5 !s_axis_tready, "input ready during a draw")

  // The top byte is the upper part of the rounded value.
  `ASSERT_CLKRST(a_top_byte, clk_i, rst_ni, m_axis_tvalid |-> m_axis_tdata[63:55] == m_axis_tdata[54:46], "top byte mismatch")

  // Rounding never goes past 2^54.
  `ASSERT_CLKRST(a_range, clk_i, rst_ni, m_axis_tvalid |-> !m_axis_tdata[54] || m_axis_tdata[53:0] == 54'd0, "rounded value out of range")

  // After reset no word is pending.
  `ASSERT_CLK(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid, "output valid right after reset")

endmodule

bind lcg48_seeded_random_draw lcg48_checker u_lcg48_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
